FILE: hw/rtl/scc_pkg.sv
// Shared constants and control types for the segment-circle collision pipeline.
`default_nettype none

package scc_pkg;

    localparam int NUM_STAGES       = 6;
    localparam int STAGE_PROD       = 4;
    localparam int STAGE_OUT        = 5;

    localparam int OUT_TDATA_WIDTH  = 8;
    localparam int OUT_COLLIDES_BIT = 0;
    localparam int OUT_FOOT_BIT     = 1;

    typedef struct packed {
        logic load_prod;
        logic load_out;
    } scc_adv_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scc_split_cmp.sv
// Split wide squares and the final exact compare of the perpendicular test.
`default_nettype none

module scc_split_cmp
    import scc_pkg::*;
#(
    parameter int MAG_WIDTH = 33,
    parameter int R2_WIDTH  = 24
)
(
    input  wire logic                 clk,
    input  wire scc_adv_t             adv,
    input  wire logic [MAG_WIDTH-1:0] cross_mag,
    input  wire logic [MAG_WIDTH-1:0] seg_len_sq,
    input  wire logic [R2_WIDTH-1:0]  radius_sq,
    input  wire logic                 foot,
    input  wire logic                 endpoint_hit,
    output logic                      collides,
    output logic                      foot_on_segment
);

    localparam int LO_W  = (MAG_WIDTH + 1) / 2;
    localparam int HI_W  = MAG_WIDTH - LO_W;
    localparam int LHS_W = 2 * MAG_WIDTH;
    localparam int RHS_W = R2_WIDTH + MAG_WIDTH;
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    logic [HI_W-1:0]          c_hi;
    logic [LO_W-1:0]          c_lo;
    logic [HI_W-1:0]          l_hi;
    logic [LO_W-1:0]          l_lo;

    logic [2*HI_W-1:0]        p_hh_reg;
    logic [HI_W+LO_W-1:0]     p_hl_reg;
    logic [2*LO_W-1:0]        p_ll_reg;
    logic [R2_WIDTH+HI_W-1:0] q_h_reg;
    logic [R2_WIDTH+LO_W-1:0] q_l_reg;
    logic                     foot5_reg;
    logic                     ep_hit5_reg;

    logic [CMP_W-1:0]         lhs;
    logic [CMP_W-1:0]         rhs;
    logic                     hit_next;
    logic                     hit_reg;
    logic                     foot6_reg;

    assign c_hi = cross_mag[MAG_WIDTH-1:LO_W];
    assign c_lo = cross_mag[LO_W-1:0];
    assign l_hi = seg_len_sq[MAG_WIDTH-1:LO_W];
    assign l_lo = seg_len_sq[LO_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.load_prod)
        begin
            p_hh_reg    <= c_hi * c_hi;
            p_hl_reg    <= c_hi * c_lo;
            p_ll_reg    <= c_lo * c_lo;
            q_h_reg     <= radius_sq * l_hi;
            q_l_reg     <= radius_sq * l_lo;
            foot5_reg   <= foot;
            ep_hit5_reg <= endpoint_hit;
        end
    end

    // The cross term appears twice in the square, hence the extra shift by one.
    always_comb
    begin
        lhs = (CMP_W'(p_hh_reg) << (2 * LO_W)) + (CMP_W'(p_hl_reg) << (LO_W + 1))
            + CMP_W'(p_ll_reg);
        rhs = (CMP_W'(q_h_reg) << LO_W) + CMP_W'(q_l_reg);
        hit_next = foot5_reg ? (lhs < rhs) : ep_hit5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_out)
        begin
            hit_reg   <= hit_next;
            foot6_reg <= foot5_reg;
        end
    end

    assign collides        = hit_reg;
    assign foot_on_segment = foot6_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/segment_circle_collision.sv
// Top level of the streaming segment versus circle collision tester.
//
// Each input beat carries a segment A-B and a circle (center, radius); each output beat
// reports whether the segment passes strictly within the radius and whether the
// perpendicular foot lies on the segment. The block takes one beat per clock while the
// output is not stalled and passes each beat through its multiplier pipeline: differences,
// squares and products, sums, magnitude and classification, split partial products of the
// wide squares, and the final exact compare. All tests are exact on squared values, so any
// fixed-point scale works as long as coordinates and radius share it. An output stall holds
// the full stages after the last empty stage; empty stages still fill.
`default_nettype none

module segment_circle_collision
    import scc_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, obstacle_x, obstacle_y,
    // obstacle_radius, then zero fill.
    input  wire logic [((6*COORD_WIDTH+8+FRAC_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // collides, foot_on_segment, then zero fill.
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    localparam int RADIUS_WIDTH = 8 + FRAC_BITS;
    localparam int DW           = COORD_WIDTH + 1;
    localparam int SW           = 2 * DW;
    localparam int MW           = 2 * COORD_WIDTH + 1;
    localparam int R2W          = 2 * RADIUS_WIDTH;
    localparam int EW           = (MW > R2W) ? MW : R2W;

    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic [RADIUS_WIDTH-1:0]       radius;

    logic [NUM_STAGES-1:0]         valid_reg;
    logic [NUM_STAGES-1:0]         adv;
    scc_adv_t                      sub_adv;
    logic                          in_fire;
    logic                          out_fire;

    logic signed [DW-1:0]          dx1_reg;
    logic signed [DW-1:0]          dy1_reg;
    logic signed [DW-1:0]          qx1_reg;
    logic signed [DW-1:0]          qy1_reg;
    logic signed [DW-1:0]          ex1_reg;
    logic signed [DW-1:0]          ey1_reg;
    logic [RADIUS_WIDTH-1:0]       r1_reg;

    logic signed [SW-1:0]          dxdx2_reg;
    logic signed [SW-1:0]          dydy2_reg;
    logic signed [SW-1:0]          qxdx2_reg;
    logic signed [SW-1:0]          qydy2_reg;
    logic signed [SW-1:0]          dxqy2_reg;
    logic signed [SW-1:0]          dyqx2_reg;
    logic signed [SW-1:0]          qxqx2_reg;
    logic signed [SW-1:0]          qyqy2_reg;
    logic signed [SW-1:0]          exex2_reg;
    logic signed [SW-1:0]          eyey2_reg;
    logic [R2W-1:0]                r2_2_reg;

    logic signed [SW-1:0]          lam3_reg;
    logic signed [SW-1:0]          dot3_reg;
    logic signed [SW-1:0]          cross3_reg;
    logic signed [SW-1:0]          d1_3_reg;
    logic signed [SW-1:0]          d2_3_reg;
    logic [R2W-1:0]                r2_3_reg;

    logic                          foot_next;
    logic                          ep_hit_next;
    logic signed [SW-1:0]          cross_abs;
    logic [EW-1:0]                 d1_ext;
    logic [EW-1:0]                 d2_ext;
    logic [EW-1:0]                 r2_ext;

    logic                          foot4_reg;
    logic                          ep_hit4_reg;
    logic [MW-1:0]                 cmag4_reg;
    logic [MW-1:0]                 lam4_reg;
    logic [R2W-1:0]                r2_4_reg;

    logic                          collides;
    logic                          foot_on_segment;

    assign ax     = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign ay     = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign bx     = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign by     = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign px     = s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign py     = s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign radius = s_axis_tdata[6*COORD_WIDTH +: RADIUS_WIDTH];

    // A stage moves on when it is empty or the stage after it moves on.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready     = adv[0];
    assign in_fire           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid     = valid_reg[NUM_STAGES-1];
    assign out_fire          = m_axis_tvalid && m_axis_tready;
    assign sub_adv.load_prod = adv[STAGE_PROD];
    assign sub_adv.load_out  = adv[STAGE_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx1_reg <= DW'(bx) - DW'(ax);
            dy1_reg <= DW'(by) - DW'(ay);
            qx1_reg <= DW'(px) - DW'(ax);
            qy1_reg <= DW'(py) - DW'(ay);
            ex1_reg <= DW'(bx) - DW'(px);
            ey1_reg <= DW'(by) - DW'(py);
            r1_reg  <= radius;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            dxdx2_reg <= dx1_reg * dx1_reg;
            dydy2_reg <= dy1_reg * dy1_reg;
            qxdx2_reg <= qx1_reg * dx1_reg;
            qydy2_reg <= qy1_reg * dy1_reg;
            dxqy2_reg <= dx1_reg * qy1_reg;
            dyqx2_reg <= dy1_reg * qx1_reg;
            qxqx2_reg <= qx1_reg * qx1_reg;
            qyqy2_reg <= qy1_reg * qy1_reg;
            exex2_reg <= ex1_reg * ex1_reg;
            eyey2_reg <= ey1_reg * ey1_reg;
            r2_2_reg  <= r1_reg * r1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            lam3_reg   <= dxdx2_reg + dydy2_reg;
            dot3_reg   <= qxdx2_reg + qydy2_reg;
            cross3_reg <= dxqy2_reg - dyqx2_reg;
            d1_3_reg   <= qxqx2_reg + qyqy2_reg;
            d2_3_reg   <= exex2_reg + eyey2_reg;
            r2_3_reg   <= r2_2_reg;
        end
    end

    // A zero-length segment has no foot and falls back to the endpoint test.
    always_comb
    begin
        foot_next   = (lam3_reg != '0) && !dot3_reg[SW-1] && (dot3_reg <= lam3_reg);
        cross_abs   = cross3_reg[SW-1] ? -cross3_reg : cross3_reg;
        d1_ext      = EW'(d1_3_reg[MW-1:0]);
        d2_ext      = EW'(d2_3_reg[MW-1:0]);
        r2_ext      = EW'(r2_3_reg);
        ep_hit_next = (d1_ext < r2_ext) || (d2_ext < r2_ext);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            foot4_reg   <= foot_next;
            ep_hit4_reg <= ep_hit_next;
            cmag4_reg   <= cross_abs[MW-1:0];
            lam4_reg    <= lam3_reg[MW-1:0];
            r2_4_reg    <= r2_3_reg;
        end
    end

    scc_split_cmp #(
        .MAG_WIDTH (MW),
        .R2_WIDTH  (R2W)
    ) u_split_cmp (
        .clk             (clk),
        .adv             (sub_adv),
        .cross_mag       (cmag4_reg),
        .seg_len_sq      (lam4_reg),
        .radius_sq       (r2_4_reg),
        .foot            (foot4_reg),
        .endpoint_hit    (ep_hit4_reg),
        .collides        (collides),
        .foot_on_segment (foot_on_segment)
    );

    always_comb
    begin
        m_axis_tdata                   = '0;
        m_axis_tdata[OUT_COLLIDES_BIT] = collides;
        m_axis_tdata[OUT_FOOT_BIT]     = foot_on_segment;
    end

    ast_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> valid_reg[0])
        else $error("Accepted beat did not enter the first stage.");

    ast_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && s_axis_tready) |-> !(&valid_reg))
        else $error("Input taken while the stalled pipeline is full.");

    ast_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) ==
            $past($countones(valid_reg)) + int'($past(in_fire)) - int'($past(out_fire)))
        else $error("Pipeline lost or duplicated a beat.");

endmodule

`default_nettype wire

FILE: tb/segment_circle_collision_test.sv
// Self-checking stream testbench for the segment versus circle collision block.
`timescale 1ns / 100ps

module segment_circle_collision_test
    import scc_pkg::*;
;

    localparam int COORD_BITS = 16;
    localparam int RADIUS_BITS = 12;
    localparam int IN_TDATA_WIDTH = ((6*COORD_BITS + 8 + 4 + 7)/8)*8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int COORD_MIN = -32768;
    localparam int COORD_MAX = 32767;

    typedef struct {
        logic signed [COORD_BITS-1:0] seg_start_x;
        logic signed [COORD_BITS-1:0] seg_start_y;
        logic signed [COORD_BITS-1:0] seg_end_x;
        logic signed [COORD_BITS-1:0] seg_end_y;
        logic signed [COORD_BITS-1:0] obstacle_x;
        logic signed [COORD_BITS-1:0] obstacle_y;
        logic [RADIUS_BITS-1:0]       obstacle_radius;
    } segment_probe_t;

    typedef struct {
        logic collides;
        logic foot_on_segment;
    } collision_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic [IN_TDATA_WIDTH-1:0] s_data = '0;
    logic m_ready = 1'b0;
    logic s_axis_tready;
    logic m_axis_tvalid;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

    segment_probe_t pending_probes[$];
    collision_t expected_hits[$];
    int mismatch_count = 0;
    int stall_cycles = 0;
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    segment_circle_collision u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic collision_t predict_collision(segment_probe_t p);
        longint ax, ay, bx, by, px, py;
        longint dx, dy, qx, qy, ex, ey;
        longint seg_len2, proj, cross_term, cross_mag, rad2, start_d2, end_d2;
        logic [127:0] cross_sq, bound;
        collision_t res;
        ax = p.seg_start_x;
        ay = p.seg_start_y;
        bx = p.seg_end_x;
        by = p.seg_end_y;
        px = p.obstacle_x;
        py = p.obstacle_y;
        rad2 = longint'(p.obstacle_radius) * longint'(p.obstacle_radius);
        dx = bx - ax;
        dy = by - ay;
        qx = px - ax;
        qy = py - ay;
        seg_len2 = dx*dx + dy*dy;
        proj = qx*dx + qy*dy;
        res.foot_on_segment = (seg_len2 > 0) && (proj >= 0) && (proj <= seg_len2);
        if (res.foot_on_segment)
        begin
            // Perpendicular distance squared times the length squared, kept exact.
            cross_term = dx*qy - dy*qx;
            cross_mag = (cross_term < 0) ? -cross_term : cross_term;
            cross_sq = 128'(cross_mag) * 128'(cross_mag);
            bound = 128'(rad2) * 128'(seg_len2);
            res.collides = cross_sq < bound;
        end
        else
        begin
            ex = bx - px;
            ey = by - py;
            start_d2 = qx*qx + qy*qy;
            end_d2 = ex*ex + ey*ey;
            res.collides = ((start_d2 < end_d2) ? start_d2 : end_d2) < rad2;
        end
        return res;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int spread(int lim);
        return int'($urandom_range(0, 2*lim)) - lim;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic add_probe(int ax, int ay, int bx, int by, int px, int py, int r);
        segment_probe_t p;
        p.seg_start_x = COORD_BITS'(ax);
        p.seg_start_y = COORD_BITS'(ay);
        p.seg_end_x = COORD_BITS'(bx);
        p.seg_end_y = COORD_BITS'(by);
        p.obstacle_x = COORD_BITS'(px);
        p.obstacle_y = COORD_BITS'(py);
        p.obstacle_radius = RADIUS_BITS'(r);
        pending_probes.push_back(p);
    endtask

    task automatic add_random_probes(int count);
        int cx, cy, span, ax, ay, bx, by, px, py, r, t, reach;
        for (int i = 0; i < count; i++)
        begin
            r = (($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400));
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                begin
                    add_probe($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 4095));
                end
                4, 5:
                begin
                    ax = int'($urandom_range(0, 65535)) - 32768;
                    ay = int'($urandom_range(0, 65535)) - 32768;
                    reach = r + 4;
                    add_probe(ax, ay, ax, ay, clamp_coord(ax + spread(reach)),
                              clamp_coord(ay + spread(reach)), r);
                end
                6:
                begin
                    add_probe(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                              edge_coord(), edge_coord(),
                              ($urandom_range(0, 1) != 0) ? 4095 : $urandom_range(0, 4095));
                end
                default:
                begin
                    // Obstacle placed near a point along the segment or just beyond either end.
                    span = ($urandom_range(0, 4) == 0) ? 16000 : $urandom_range(1, 600);
                    cx = int'($urandom_range(0, 65535)) - 32768;
                    cy = int'($urandom_range(0, 65535)) - 32768;
                    ax = clamp_coord(cx + spread(span));
                    ay = clamp_coord(cy + spread(span));
                    bx = clamp_coord(cx + spread(span));
                    by = clamp_coord(cy + spread(span));
                    t = int'($urandom_range(0, 1424)) - 200;
                    reach = r + r/2 + 2;
                    px = clamp_coord(ax + ((bx - ax)*t)/1024 + spread(reach));
                    py = clamp_coord(ay + ((by - ay)*t)/1024 + spread(reach));
                    add_probe(ax, ay, bx, by, px, py, r);
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_probes.size() != 0 || s_valid || expected_hits.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
            s_data <= '0;
        end
        else if (!s_valid || s_axis_tready)
        begin
            if (pending_probes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_data <= {4'b0, pending_probes[0].obstacle_radius,
                           pending_probes[0].obstacle_y, pending_probes[0].obstacle_x,
                           pending_probes[0].seg_end_y, pending_probes[0].seg_end_x,
                           pending_probes[0].seg_start_y, pending_probes[0].seg_start_x};
                void'(pending_probes.pop_front());
                s_valid <= 1'b1;
            end
            else
            begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        segment_probe_t seen;
        collision_t want;
        if (rst_n)
        begin
            if (s_valid && s_axis_tready)
            begin
                seen.seg_start_x = s_data[15:0];
                seen.seg_start_y = s_data[31:16];
                seen.seg_end_x = s_data[47:32];
                seen.seg_end_y = s_data[63:48];
                seen.obstacle_x = s_data[79:64];
                seen.obstacle_y = s_data[95:80];
                seen.obstacle_radius = s_data[107:96];
                expected_hits.push_back(predict_collision(seen));
            end
            if (m_axis_tvalid && m_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected result beat, tdata %h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (m_axis_tdata[OUT_COLLIDES_BIT] !== want.collides)
                    begin
                        $error("collides: expected %0b, actual %0b", want.collides,
                               m_axis_tdata[OUT_COLLIDES_BIT]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[OUT_FOOT_BIT] !== want.foot_on_segment)
                    begin
                        $error("foot_on_segment: expected %0b, actual %0b",
                               want.foot_on_segment, m_axis_tdata[OUT_FOOT_BIT]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("segment_circle_collision_test: errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 20;
        take_idle_pct = 20;
        add_probe(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 4095);
        add_probe(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 4095);
        add_probe(-1, -1, -1, -1, -1, -1, 4095);
        add_probe(100, 100, 100, 100, 105, 100, 6);
        add_probe(100, 100, 100, 100, 105, 100, 5);
        add_probe(0, 0, 160, 0, 80, 0, 0);
        add_probe(0, 0, 160, 0, 80, 30, 31);
        add_probe(0, 0, 160, 0, 80, 30, 30);
        add_probe(0, 0, 160, 0, 0, 50, 51);
        add_probe(0, 0, 160, 0, 160, -50, 50);
        add_probe(0, 0, 160, 0, 200, 0, 41);
        add_probe(0, 0, 160, 0, 200, 0, 40);
        add_probe(0, 0, 160, 0, -30, 40, 51);
        add_probe(0, 0, 160, 0, -30, 40, 50);
        add_probe(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN + 1, COORD_MAX, COORD_MAX, 4095);
        add_probe(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 0);
        add_probe(30, 40, -30, -40, 24, -32, 4095);
        add_probe(0, 0, COORD_MAX, 0, 16384, 4095, 4095);
        add_probe(COORD_MIN, 0, COORD_MIN, 0, COORD_MIN, 0, 1);
        add_probe(0, 0, 0, 0, 0, 0, 0);
        wait_drained();

        send_idle_pct = 0;
        take_idle_pct = 0;
        add_random_probes(300);
        wait_drained();

        send_idle_pct = 20;
        take_idle_pct = 20;
        add_random_probes(530);
        wait_drained();

        repeat (12) @(negedge clk);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("segment_circle_collision_test: clean");
        else
            $display("segment_circle_collision_test: errors");
        $finish;
    end

endmodule
